@@ rtl/qtps_pkg.sv @@
// Package for the quintic trajectory pulse step block.
// Shared types and fixed-point constants; no dependencies.
`default_nettype none
package qtps_pkg;
  localparam logic [23:0] RoundUpQ24 = 24'd12247367;
  localparam logic signed [47:0] AngleMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] AngleMin = 48'sh8000_0000_0000;
  localparam logic [8:0] DegPerRev = 9'd360;
  // ceil(2^30 / 360): exact quotient for dividends below 360 * 4096
  localparam logic [21:0] Recip360 = 22'd2982617;
  // ceil(2^38 / 360): exact quotient for dividends below 2^29
  localparam logic [29:0] Recip360Wide = 30'd763549742;

  localparam logic ActTick = 1'b0;
  localparam logic ActLoad = 1'b1;

  // Item classified by the front part.
  typedef struct packed {
    logic        is_load;
    logic        all_zero;
    logic [15:0] step_index;
    logic [15:0] correction;
  } cmd_t;
endpackage
`default_nettype wire

@@ rtl/qtps_front.sv @@
// Front part: accepts input items, classifies them and queues them.
// Depends on qtps_pkg.
`default_nettype none
module qtps_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [31:0]       s_tdata,
  input  wire logic              s_tuser,
  input  wire logic              coef_zero,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output qtps_pkg::cmd_t         q_cmd
);
  // two-entry queue
  qtps_pkg::cmd_t mem [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  qtps_pkg::cmd_t cmd_in;
  logic push, pop;

  always_comb begin
    cmd_in.is_load    = (s_tuser == qtps_pkg::ActLoad);
    cmd_in.all_zero   = coef_zero;
    cmd_in.step_index = s_tdata[15:0];
    cmd_in.correction = s_tdata[31:16];
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ rtl/qtps_back.sv @@
// Back part: Horner evaluation on one shared multiplier, pulse scaling,
// rounding and correction. Depends on qtps_pkg.
`default_nettype none
module qtps_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire qtps_pkg::cmd_t     q_cmd,
  input  wire logic [5:0][47:0]   coefs,
  input  wire logic [19:0]        pulses_per_rev,
  input  wire logic [23:0]        tick_interval,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [15:0]             pulse_count,
  output logic                    direction
);
  typedef enum logic [3:0] {
    S_IDLE, S_TIME, S_MHI, S_MLO, S_ADD, S_DIFF, S_DIV, S_SCALE,
    S_SCALE2, S_ROUND, S_RDIV, S_FIN
  } state_t;

  state_t state;
  qtps_pkg::cmd_t cmd;
  logic [31:0] t;
  logic signed [47:0] acc, prev_angle;
  logic [2:0] idx;
  logic neg;
  logic [47:0] mag;
  logic [55:0] p_hi_full;
  logic [55:0] m_sum;
  logic [47:0] q;      // |angle difference| / 360, four 12-bit digits
  logic [8:0]  r;
  logic [1:0]  div_cnt;
  logic        div_ph;
  logic [11:0] qd;
  logic [20:0] div_xr;
  logic [47:0] div_num;
  logic [67:0] amount;
  logic [67:0] prod_a;
  logic [28:0] prod_b;
  logic signed [31:0] frac_acc;
  logic signed [15:0] pending;
  logic pos_dir;

  // shared multiplier operands, 32 x 32
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // next partial dividend: remainder followed by the next 12-bit digit
  logic [20:0] div_x;
  assign div_x = {r, div_num[47:36]};

  logic [23:0] frac;
  assign frac = amount[23:0];

  logic signed [49:0] next_add;

  assign q_ready = (state == S_IDLE) && !m_tvalid;

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_TIME:  begin mul_a = {16'd0, cmd.step_index}; mul_b = {8'd0, tick_interval}; end
      S_MHI:   begin mul_a = {8'd0, mag[47:24]}; mul_b = t; end
      S_MLO:   begin mul_a = {8'd0, mag[23:0]}; mul_b = t; end
      S_DIV:   begin mul_a = {11'd0, div_x}; mul_b = {10'd0, qtps_pkg::Recip360}; end
      S_SCALE: begin mul_a = q[31:0]; mul_b = {12'd0, pulses_per_rev}; end
      S_SCALE2: begin mul_a = {16'd0, q[47:32]}; mul_b = {12'd0, pulses_per_rev}; end
      S_ROUND: begin mul_a = {23'd0, r}; mul_b = {12'd0, pulses_per_rev}; end
      S_RDIV:  begin mul_a = {3'd0, prod_b}; mul_b = {2'd0, qtps_pkg::Recip360Wide}; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      prev_angle <= '0;
      frac_acc   <= '0;
      pending    <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cmd <= q_cmd;
            if (q_cmd.is_load) begin
              pending <= q_cmd.correction;
            end else if (q_cmd.all_zero) begin
              pulse_count <= 16'd0;
              direction   <= 1'b0;
              m_tvalid    <= 1'b1;
            end else begin
              state <= S_TIME;
            end
          end
        end
        S_TIME: begin
          t   <= (mul_p[63:32] != 32'd0) ? 32'hFFFF_FFFF : mul_p[31:0];
          acc <= coefs[5];
          idx <= 3'd4;
          neg <= coefs[5][47];
          mag <= coefs[5][47] ? 48'(-coefs[5]) : coefs[5];
          state <= S_MHI;
        end
        S_MHI: begin
          p_hi_full <= {mul_p[55:0]};
          state <= S_MLO;
        end
        S_MLO: begin
          m_sum <= p_hi_full + 56'(mul_p[55:24]);
          state <= S_ADD;
        end
        S_ADD: begin
          if (next_add > 50'(qtps_pkg::AngleMax)) acc <= qtps_pkg::AngleMax;
          else if (next_add < 50'(qtps_pkg::AngleMin)) acc <= qtps_pkg::AngleMin;
          else acc <= next_add[47:0];
          if (idx == 3'd0) begin
            state <= S_DIFF;
          end else begin
            idx <= idx - 3'd1;
            state <= S_MHI;
            if (next_add > 50'(qtps_pkg::AngleMax)) begin
              neg <= 1'b0; mag <= 48'(qtps_pkg::AngleMax);
            end else if (next_add < 50'(qtps_pkg::AngleMin)) begin
              neg <= 1'b1; mag <= 48'h8000_0000_0000;
            end else begin
              neg <= next_add[49];
              mag <= next_add[49] ? 48'(-next_add) : next_add[47:0];
            end
          end
        end
        S_DIFF: begin
          begin
            logic signed [48:0] d;
            d = 49'(acc) - 49'(prev_angle);
            pos_dir <= (d > 49'sd0);
            div_num <= d[48] ? 48'(-d) : d[47:0];
          end
          prev_angle <= acc;
          r <= 9'd0;
          q <= '0;
          div_cnt <= 2'd0;
          div_ph <= 1'b0;
          state <= S_DIV;
        end
        S_DIV: begin
          // each 12-bit quotient digit: estimate first, then remainder
          if (!div_ph) begin
            qd <= mul_p[41:30];
            div_xr <= div_x;
            div_ph <= 1'b1;
          end else begin
            r <= 9'(div_xr - 21'(qd) * 21'(qtps_pkg::DegPerRev));
            q <= {q[35:0], qd};
            div_num <= {div_num[35:0], 12'd0};
            div_ph <= 1'b0;
            div_cnt <= div_cnt + 2'd1;
            if (div_cnt == 2'd3) state <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod_a <= 68'(mul_p[51:0]);
          state <= S_SCALE2;
        end
        S_SCALE2: begin
          prod_a <= prod_a + {mul_p[35:0], 32'd0};
          state <= S_ROUND;
        end
        S_ROUND: begin
          prod_b <= mul_p[28:0];
          state <= S_RDIV;
        end
        S_RDIV: begin
          amount <= prod_a + 68'(mul_p[63:38]);
          state <= S_FIN;
        end
        S_FIN: begin
          begin
            logic [52:0] p;
            logic signed [32:0] fa;
            logic signed [15:0] pc;
            p = 53'(amount[67:24]);
            if (frac > qtps_pkg::RoundUpQ24) begin
              p = p + 53'd1;
              fa = 33'(frac_acc) + 33'(frac) - 33'sh100_0000;
            end else begin
              fa = 33'(frac_acc) + 33'(frac);
            end
            if (fa >= 33'sh100_0000) begin
              fa = fa - 33'sh100_0000;
              p = p + 53'd1;
            end else if (fa <= -33'sh100_0000) begin
              if (p != 53'd0) begin
                fa = fa + 33'sh100_0000;
                p = p - 53'd1;
              end
            end
            pc = pending;
            if (pc > 16'sd0) begin
              p = p + 53'd1;
              pc = pc - 16'sd1;
            end else if (pc < 16'sd0) begin
              if (p > 53'd1) begin
                p = p - 53'd1;
                pc = pc + 16'sd1;
              end
            end
            frac_acc <= fa[31:0];
            pending  <= pc;
            pulse_count <= (p > 53'hFFFF) ? 16'hFFFF : p[15:0];
          end
          direction <= pos_dir;
          m_tvalid  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // truncated product magnitude with sign restored, plus coefficient
  always_comb begin
    logic [55:0] ms;
    logic signed [49:0] sp;
    ms = m_sum;
    if (neg) sp = (ms > 56'h8000_0000_0000) ? -50'sh8000_0000_0000 : -50'(ms);
    else sp = (ms > 56'h7FFF_FFFF_FFFF) ? 50'sh7FFF_FFFF_FFFF : 50'(ms);
    next_add = sp + 50'($signed(coefs[idx]));
  end
endmodule
`default_nettype wire

@@ rtl/quintic_trajectory_pulse_step.sv @@
// Top level of the quintic trajectory pulse step block.
// Holds the configuration registers; uses qtps_front, qtps_back, qtps_pkg.
//
// One axis. A tick item leaving the queue passes through the back part's
// states in order: t from the step index, then each Horner step on one
// shared 32x32 multiplier (high half, low half, add), the angle difference,
// the divide by 360 (four 12-bit digits by reciprocal multiplication, each
// an estimate then a remainder) and scaling and rounding. The back part
// takes the next item only after the result is taken. A load item or a tick
// with all coefficients zero is settled in the idle state. A two-entry queue
// parts the input from the back part, and the result register holds an item
// until taken while the next ones queue.
`default_nettype none
module quintic_trajectory_pulse_step (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // step_index[15:0], correction[31:16]
  input  wire logic        s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // pulse_count[15:0], direction[16], zero pad
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  logic [5:0][47:0] coefs;
  logic [19:0] pulses_per_rev;
  logic [23:0] tick_interval;
  logic q_valid, q_ready;
  qtps_pkg::cmd_t q_cmd;
  logic [15:0] pulse_count;
  logic direction;
  logic coef_zero;

  assign coef_zero = (coefs == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
      pulses_per_rev <= 20'd25000;
      tick_interval <= 24'd167772;
    end else if (cfg_we) begin
      if (cfg_index < 3'd6) coefs[cfg_index] <= cfg_data;
      else if (cfg_index == 3'd6) pulses_per_rev <= cfg_data[19:0];
      else tick_interval <= cfg_data[23:0];
    end
  end

  qtps_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .coef_zero, .q_valid, .q_ready, .q_cmd
  );

  qtps_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .coefs, .pulses_per_rev,
    .tick_interval, .m_tvalid, .m_tready, .pulse_count, .direction
  );

  assign m_tdata = {7'd0, direction, pulse_count};
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for quintic_trajectory_pulse_step.
// Directed table then randomized trajectory phases, checked by an in-bench predictor.
// Depends on qtps_pkg and the RTL top level only.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegCoef0 = 3'd0;
  localparam logic [2:0] RegCoef1 = 3'd1;
  localparam logic [2:0] RegCoef5 = 3'd5;
  localparam logic [2:0] RegPpr   = 3'd6;
  localparam logic [2:0] RegTick  = 3'd7;
  localparam int unsigned SettleCycles = 120;
  localparam longint OneQ24 = 64'sd16777216;
  localparam longint AMax = 64'sh7FFF_FFFF_FFFF;
  localparam longint AMin = -64'sh8000_0000_0000;

  typedef enum logic [1:0] {RowItem, RowCfg} row_kind_t;
  typedef struct {
    row_kind_t   kind;
    logic        act;
    logic [15:0] step;
    logic [15:0] corr;
    logic [2:0]  idx;
    logic [47:0] val;
    bit          typed;
    logic [15:0] t_pulse;
    logic        t_dir;
  } row_t;
  typedef struct {
    logic [15:0] pulse;
    logic        dir;
  } pulse_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  quintic_trajectory_pulse_step dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  // predictor state and configuration
  longint coef_q[6];
  longint ppr_q, tint_q;
  longint prev_angle_q, frac_acc_q, pend_corr_q;
  pulse_out_t pulses_due[$];
  int errors = 0;
  bit calm = 1'b0;

  function automatic longint clamp_angle(longint v);
    if (v > AMax) return AMax;
    if (v < AMin) return AMin;
    return v;
  endfunction

  function automatic longint scale_by_t(longint a, longint unsigned t);
    longint unsigned mag, m;
    bit neg;
    neg = a < 0;
    mag = neg ? longint'(-a) : a;
    m = (mag >> 24) * t + (((mag & 64'hFFFFFF) * t) >> 24);
    if (neg) begin
      if (m > (64'd1 << 47)) m = 64'd1 << 47;
      return -longint'(m);
    end
    if (m > AMax) m = AMax;
    return longint'(m);
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [47:0] v);
    if (idx <= RegCoef5) coef_q[idx] = longint'(signed'(v));
    else if (idx == RegPpr) ppr_q = v[19:0];
    else tint_q = v[23:0];
  endfunction

  // one tick: angle polynomial, pulse scaling, rounding and correction
  function automatic pulse_out_t predict_tick(logic [15:0] k);
    pulse_out_t o;
    longint unsigned t, mag, amount, frac, pulse;
    longint angle, diff;
    o = '{16'd0, 1'b0};
    if (coef_q[0] == 0 && coef_q[1] == 0 && coef_q[2] == 0 &&
        coef_q[3] == 0 && coef_q[4] == 0 && coef_q[5] == 0) return o;
    t = longint'(k) * tint_q;
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    angle = coef_q[5];
    for (int i = 4; i >= 0; i--) angle = clamp_angle(scale_by_t(angle, t) + coef_q[i]);
    diff = angle - prev_angle_q;
    mag = diff < 0 ? longint'(-diff) : diff;
    amount = (mag / 360) * ppr_q + ((mag % 360) * ppr_q) / 360;
    frac = amount & 64'hFFFFFF;
    pulse = amount >> 24;
    if (frac > qtps_pkg::RoundUpQ24) begin
      pulse++;
      frac_acc_q += longint'(frac) - OneQ24;
    end else begin
      frac_acc_q += longint'(frac);
    end
    if (frac_acc_q >= OneQ24) begin
      frac_acc_q -= OneQ24;
      pulse++;
    end else if (frac_acc_q <= -OneQ24 && pulse > 0) begin
      frac_acc_q += OneQ24;
      pulse--;
    end
    if (pend_corr_q > 0) begin
      pulse++;
      pend_corr_q--;
    end else if (pend_corr_q < 0 && pulse > 1) begin
      pulse--;
      pend_corr_q++;
    end
    prev_angle_q = angle;
    o.pulse = pulse > 64'hFFFF ? 16'hFFFF : pulse[15:0];
    o.dir = diff > 0;
    return o;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // result monitor
  always @(posedge clk) begin
    pulse_out_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pulses_due.size() == 0) begin
        report_mismatch("result with none expected");
      end else begin
        e = pulses_due.pop_front();
        if (m_tdata[15:0] !== e.pulse)
          report_mismatch($sformatf("pulse_count %0d, expected %0d", m_tdata[15:0], e.pulse));
        if (m_tdata[16] !== e.dir)
          report_mismatch($sformatf("direction %0b, expected %0b", m_tdata[16], e.dir));
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 9);
  end

  task automatic wait_idle();
    while (pulses_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [47:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // present one item from the falling edge, hold until accepted
  task automatic send_item(logic act, logic [15:0] step, logic [15:0] corr,
                           bit typed, pulse_out_t typed_out);
    pulse_out_t p;
    while (!calm && $urandom_range(99) < 9) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = act;
    s_tdata = {corr, step};
    do @(posedge clk); while (!s_tready);
    if (act == qtps_pkg::ActLoad) begin
      pend_corr_q = longint'(signed'(corr));
    end else begin
      p = predict_tick(step);
      pulses_due.push_back(typed ? typed_out : p);
    end
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  function automatic logic [47:0] rand_coef();
    logic [47:0] v;
    int w;
    v = 48'({$urandom, $urandom});
    if ($urandom_range(9) == 0) return v;
    w = $urandom_range(1, 44);
    v = v & ((48'd1 << w) - 48'd1);
    return $urandom_range(1) ? -v : v;
  endfunction

  row_t plan[$];

  function automatic row_t item_row(logic act, logic [15:0] s, logic [15:0] c);
    return '{RowItem, act, s, c, 3'd0, 48'd0, 1'b0, 16'd0, 1'b0};
  endfunction
  function automatic row_t cfg_row(logic [2:0] i, logic [47:0] v);
    return '{RowCfg, qtps_pkg::ActTick, 16'd0, 16'd0, i, v, 1'b0, 16'd0, 1'b0};
  endfunction

  initial begin
    row_t r;
    logic [15:0] k;
    logic [15:0] c;
    for (int i = 0; i < 6; i++) coef_q[i] = 0;
    ppr_q = 25000;
    tint_q = 167772;
    prev_angle_q = 0;
    frac_acc_q = 0;
    pend_corr_q = 0;

    // all coefficients zero after reset: no motion
    plan.push_back('{RowItem, qtps_pkg::ActTick, 16'h0000, 16'h0000, 3'd0, 48'd0,
                     1'b1, 16'd0, 1'b0});
    plan.push_back('{RowItem, qtps_pkg::ActTick, 16'hFFFF, 16'hFFFF, 3'd0, 48'd0,
                     1'b1, 16'd0, 1'b0});
    plan.push_back(item_row(qtps_pkg::ActLoad, 16'hFFFF, 16'h7FFF));
    plan.push_back(item_row(qtps_pkg::ActLoad, 16'h0000, 16'h8000));
    plan.push_back(item_row(qtps_pkg::ActLoad, 16'h1234, 16'h0000));
    plan.push_back(cfg_row(RegCoef1, 48'd10 << 24));
    plan.push_back(cfg_row(RegPpr, 48'd360));
    plan.push_back(cfg_row(RegTick, 48'd1 << 24));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'd1, 16'h0));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'd3, 16'h0));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'd2, 16'h0));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'd2, 16'h0));
    plan.push_back(item_row(qtps_pkg::ActLoad, 16'd0, 16'd3));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'd5, 16'h0));
    plan.push_back(item_row(qtps_pkg::ActLoad, 16'd0, -16'sd2));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'd6, 16'h0));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'd7, 16'h0));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'd7, 16'h0));
    plan.push_back(cfg_row(RegCoef0, 48'h7FFF_FFFF_FFFF));
    plan.push_back(cfg_row(RegCoef5, 48'h7FFF_FFFF_FFFF));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'hFFFF, 16'h0));
    plan.push_back(cfg_row(RegCoef5, 48'h8000_0000_0000));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'hFFFF, 16'h0));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'd0, 16'h0));
    plan.push_back(cfg_row(RegPpr, 48'd1048575));
    plan.push_back(cfg_row(RegTick, 48'hFF_FFFF));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'd1, 16'h0));
    plan.push_back(cfg_row(RegPpr, 48'd1));
    plan.push_back(cfg_row(RegTick, 48'd1));
    plan.push_back(item_row(qtps_pkg::ActTick, 16'd40000, 16'h0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == RowCfg) begin
        wait_idle();
        cfg_write(r.idx, r.val);
      end else begin
        send_item(r.act, r.step, r.corr, r.typed, '{r.t_pulse, r.t_dir});
      end
    end

    // hold off until the block has drained
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      calm = (ph == 4);
      for (logic [3:0] i = 0; i <= RegCoef5; i++)
        cfg_write(i[2:0], (ph == 7) ? 48'd0 : rand_coef());
      case (ph)
        2: begin
          cfg_write(RegPpr, 48'd1048575);
          cfg_write(RegTick, 48'hFF_FFFF);
        end
        5: begin
          cfg_write(RegPpr, 48'd1);
          cfg_write(RegTick, 48'd1);
        end
        default: begin
          cfg_write(RegPpr, 48'($urandom_range(1, 1048575)));
          cfg_write(RegTick, $urandom_range(1) ? 48'($urandom_range(1, 16777215))
                                                : 48'($urandom_range(1, 4096)));
        end
      endcase
      k = $urandom_range(1) ? 16'd0 : 16'($urandom);
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(99) < 15) begin
          c = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(6)) - 16'd3;
          send_item(qtps_pkg::ActLoad, 16'($urandom), c, 1'b0, '{16'd0, 1'b0});
        end else begin
          // mostly a steady walk along the trajectory, now and then a jump
          k = ($urandom_range(19) == 0) ? 16'($urandom) : k + 16'($urandom_range(4));
          send_item(qtps_pkg::ActTick, k, 16'($urandom), 1'b0, '{16'd0, 1'b0});
        end
      end
    end
    calm = 1'b0;

    while (pulses_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/qtps_pkg.sv
rtl/qtps_front.sv
rtl/qtps_back.sv
rtl/quintic_trajectory_pulse_step.sv
test/tb_top.sv
